FILE: hw/rtl/rrs_pkg.sv
// ----------------------------------------------------------------------------
// rrs_pkg
// Types, stage map and per-stage step functions for the ray setup pipeline.
// ----------------------------------------------------------------------------
package rrs_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int WIDTH_W     = 13;
    localparam int COL_W       = 12;
    localparam int POS_W       = 24;
    localparam int VEC_W       = 19;
    localparam int RAY_W       = 20;
    localparam int CELL_W      = 8;
    localparam int DIST_W      = 32;

    localparam int CAM_NUM_W   = COL_W + 1 + FRAC_BITS;   // 29
    localparam int CAM_W       = CAM_NUM_W + 1;           // 30
    localparam int PROD_W      = VEC_W + CAM_W;           // 49
    localparam int SQ_W        = 2 * RAY_W;               // 40
    localparam int SQ_REM_W    = RAY_W + 3;               // 23
    localparam int HYP_W       = RAY_W;                   // 20
    localparam int DV_NUM_W    = HYP_W + FRAC_BITS;       // 36
    localparam int DV_REM_W    = RAY_W;                   // 20
    localparam int DIST1_W     = FRAC_BITS + 1;           // 17
    localparam int SIDE_PROD_W = DIST1_W + DIST_W;        // 49

    localparam logic [WIDTH_W-1:0] WIDTH_RESET = 13'd640;
    localparam logic [DIST_W-1:0]  DIST_SAT    = '1;
    localparam logic signed [RAY_W-1:0] RAY_MAX = 20'sh7FFFF;
    localparam logic signed [RAY_W-1:0] RAY_MIN = 20'sh80000;

    // stage map
    localparam int DIV1_STEPS    = CAM_NUM_W;
    localparam int ST_DIV1_FIRST = 1;
    localparam int ST_CAM        = ST_DIV1_FIRST + DIV1_STEPS;   // 30
    localparam int ST_RAY        = ST_CAM + 1;
    localparam int ST_SQ         = ST_RAY + 1;
    localparam int SQRT_STEPS    = HYP_W;
    localparam int ST_SQRT_FIRST = ST_SQ + 1;
    localparam int ST_HYP        = ST_SQRT_FIRST + SQRT_STEPS;
    localparam int DIV2_STEPS    = DV_NUM_W;
    localparam int ST_DIV2_FIRST = ST_HYP + 1;
    localparam int ST_DELTA      = ST_DIV2_FIRST + DIV2_STEPS;
    localparam int ST_SIDE_MUL   = ST_DELTA + 1;
    localparam int ST_SIDE       = ST_SIDE_MUL + 1;
    localparam int NUM_STAGES    = ST_SIDE + 1;

    typedef struct packed {
        logic [CELL_W-1:0]          cell_x;
        logic [CELL_W-1:0]          cell_y;
        logic [FRAC_BITS-1:0]       frac_x;
        logic [FRAC_BITS-1:0]       frac_y;
        logic signed [VEC_W-1:0]    dir_x;
        logic signed [VEC_W-1:0]    dir_y;
        logic signed [VEC_W-1:0]    pl_x;
        logic signed [VEC_W-1:0]    pl_y;
        logic [CAM_NUM_W-1:0]       cam_num;
        logic [WIDTH_W-1:0]         cam_rem;
        logic [CAM_NUM_W-1:0]       cam_quo;
        logic signed [PROD_W-1:0]   prod_x;
        logic signed [PROD_W-1:0]   prod_y;
        logic signed [RAY_W-1:0]    ray_x;
        logic signed [RAY_W-1:0]    ray_y;
        logic [RAY_W-1:0]           mag_x;
        logic [RAY_W-1:0]           mag_y;
        logic [SQ_W-1:0]            sq_num;
        logic [SQ_REM_W-1:0]        sq_rem;
        logic [HYP_W-1:0]           sq_root;
        logic [DV_NUM_W-1:0]        dvx_num;
        logic [DV_REM_W-1:0]        dvx_rem;
        logic [DV_NUM_W-1:0]        dvx_quo;
        logic [DV_NUM_W-1:0]        dvy_num;
        logic [DV_REM_W-1:0]        dvy_rem;
        logic [DV_NUM_W-1:0]        dvy_quo;
        logic [DIST_W-1:0]          delta_x;
        logic [DIST_W-1:0]          delta_y;
        logic [DIST1_W-1:0]         dist_x;
        logic [DIST1_W-1:0]         dist_y;
        logic [SIDE_PROD_W-1:0]     sprod_x;
        logic [SIDE_PROD_W-1:0]     sprod_y;
        logic [DIST_W-1:0]          side_x;
        logic [DIST_W-1:0]          side_y;
    } item_t;

    // one restoring step of the camera coordinate divide
    function automatic item_t div1_step(item_t it, logic [WIDTH_W-1:0] w);
        item_t o;
        logic [WIDTH_W:0] r;
        o = it;
        r = {it.cam_rem, it.cam_num[CAM_NUM_W-1]};
        o.cam_num = {it.cam_num[CAM_NUM_W-2:0], 1'b0};
        if (r >= {1'b0, w}) begin
            o.cam_rem = WIDTH_W'(r - {1'b0, w});
            o.cam_quo = {it.cam_quo[CAM_NUM_W-2:0], 1'b1};
        end else begin
            o.cam_rem = r[WIDTH_W-1:0];
            o.cam_quo = {it.cam_quo[CAM_NUM_W-2:0], 1'b0};
        end
        return o;
    endfunction

    // one digit of the integer square root
    function automatic item_t sqrt_step(item_t it);
        item_t o;
        logic [SQ_REM_W-1:0] r;
        logic [SQ_REM_W-1:0] trial;
        o = it;
        r = {it.sq_rem[SQ_REM_W-3:0], it.sq_num[SQ_W-1:SQ_W-2]};
        trial = {1'b0, it.sq_root, 2'b01};
        o.sq_num = {it.sq_num[SQ_W-3:0], 2'b00};
        if (r >= trial) begin
            o.sq_rem  = r - trial;
            o.sq_root = {it.sq_root[HYP_W-2:0], 1'b1};
        end else begin
            o.sq_rem  = r;
            o.sq_root = {it.sq_root[HYP_W-2:0], 1'b0};
        end
        return o;
    endfunction

    // one restoring divide step of rem/num/quo by mag
    function automatic logic [DV_REM_W+2*DV_NUM_W-1:0] div2_core(
        logic [DV_REM_W-1:0] rem, logic [DV_NUM_W-1:0] num,
        logic [DV_NUM_W-1:0] quo, logic [RAY_W-1:0] mag);
        logic [DV_REM_W:0]   r;
        logic [DV_REM_W-1:0] rn;
        logic                qb;
        r = {rem, num[DV_NUM_W-1]};
        if (r >= {1'b0, mag}) begin
            rn = DV_REM_W'(r - {1'b0, mag});
            qb = 1'b1;
        end else begin
            rn = r[DV_REM_W-1:0];
            qb = 1'b0;
        end
        return {rn, num[DV_NUM_W-2:0], 1'b0, quo[DV_NUM_W-2:0], qb};
    endfunction

    function automatic item_t div2_step(item_t it);
        item_t o;
        o = it;
        {o.dvx_rem, o.dvx_num, o.dvx_quo} =
            div2_core(it.dvx_rem, it.dvx_num, it.dvx_quo, it.mag_x);
        {o.dvy_rem, o.dvy_num, o.dvy_quo} =
            div2_core(it.dvy_rem, it.dvy_num, it.dvy_quo, it.mag_y);
        return o;
    endfunction

    function automatic logic signed [RAY_W-1:0] ray_sat(
        logic signed [VEC_W-1:0] dir, logic signed [PROD_W-1:0] prod);
        logic signed [PROD_W-FRAC_BITS:0] s;
        s = (PROD_W-FRAC_BITS+1)'(dir) + (PROD_W-FRAC_BITS+1)'(prod >>> FRAC_BITS);
        if (s > (PROD_W-FRAC_BITS+1)'(RAY_MAX))
            return RAY_MAX;
        else if (s < (PROD_W-FRAC_BITS+1)'(RAY_MIN))
            return RAY_MIN;
        else
            return s[RAY_W-1:0];
    endfunction

    function automatic logic [DIST_W-1:0] delta_of(
        logic [RAY_W-1:0] mag, logic [DV_NUM_W-1:0] quo);
        if (mag == '0 || quo[DV_NUM_W-1:DIST_W] != '0)
            return DIST_SAT;
        else
            return quo[DIST_W-1:0];
    endfunction

    function automatic logic [DIST1_W-1:0] dist_of(logic neg, logic [FRAC_BITS-1:0] frac);
        if (neg)
            return {1'b0, frac};
        else
            return (DIST1_W'(1) << FRAC_BITS) - {1'b0, frac};
    endfunction

    function automatic logic [DIST_W-1:0] side_of(
        logic [DIST_W-1:0] delta, logic [SIDE_PROD_W-1:0] prod);
        if (delta == DIST_SAT || prod[SIDE_PROD_W-1:FRAC_BITS+DIST_W] != '0)
            return DIST_SAT;
        else
            return prod[FRAC_BITS+DIST_W-1:FRAC_BITS];
    endfunction

endpackage

FILE: hw/rtl/raycast_ray_setup.sv
// ----------------------------------------------------------------------------
// raycast_ray_setup
// Per-column setup of a grid-walking ray: direction, cell, step, delta, side.
// ----------------------------------------------------------------------------
// One request per screen column goes in and one result comes out, in order.
// The block is a 93-stage pipeline: a bit-serial divide for the camera
// coordinate (29 stages), multiply and saturate, squaring, a digit-by-digit
// square root (20 stages), two parallel restoring divides for the delta
// distances (36 stages) and a multiply for the side distances. It takes a new
// request every cycle while m_ready is high. The whole pipeline holds when the
// result at the end is not taken, so s_ready follows m_ready whenever the
// output stage is full. screen_width is written through cfg_we/cfg_wdata,
// by the user only while no request is in flight; the block does not enforce
// this. A width of zero behaves as one. Zero ray components give all-ones
// delta and side distances.
module raycast_ray_setup (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_we,
    input  logic [rrs_pkg::WIDTH_W-1:0]        cfg_wdata,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [rrs_pkg::COL_W-1:0]          s_column,
    input  logic [rrs_pkg::POS_W-1:0]          s_player_x,
    input  logic [rrs_pkg::POS_W-1:0]          s_player_y,
    input  logic signed [rrs_pkg::VEC_W-1:0]   s_view_dir_x,
    input  logic signed [rrs_pkg::VEC_W-1:0]   s_view_dir_y,
    input  logic signed [rrs_pkg::VEC_W-1:0]   s_plane_x,
    input  logic signed [rrs_pkg::VEC_W-1:0]   s_plane_y,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [rrs_pkg::RAY_W-1:0]   m_ray_x,
    output logic signed [rrs_pkg::RAY_W-1:0]   m_ray_y,
    output logic [rrs_pkg::CELL_W-1:0]         m_cell_x,
    output logic [rrs_pkg::CELL_W-1:0]         m_cell_y,
    output logic                               m_step_neg_x,
    output logic                               m_step_neg_y,
    output logic [rrs_pkg::DIST_W-1:0]         m_delta_x,
    output logic [rrs_pkg::DIST_W-1:0]         m_delta_y,
    output logic [rrs_pkg::DIST_W-1:0]         m_side_x,
    output logic [rrs_pkg::DIST_W-1:0]         m_side_y
);
    import rrs_pkg::*;

    logic [WIDTH_W-1:0]    screen_width_reg;
    logic [WIDTH_W-1:0]    div_w;
    logic [NUM_STAGES-1:0] vld_reg;
    logic [NUM_STAGES-1:0] vld_next;
    item_t                 pipe_reg  [NUM_STAGES];
    item_t                 pipe_next [NUM_STAGES];
    logic                  advance;

    // config register; the user must write it only while idle, the block does not enforce this
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            screen_width_reg <= WIDTH_RESET;
        end else if (cfg_we) begin
            screen_width_reg <= cfg_wdata;
        end
    end

    // zero width divides as one
    assign div_w = (screen_width_reg == '0) ? WIDTH_W'(1) : screen_width_reg;

    // global stall: everything moves when the output slot is free or taken
    assign advance = m_ready || !vld_reg[NUM_STAGES-1];
    assign s_ready = advance;

    assign vld_next = {vld_reg[NUM_STAGES-2:0], s_valid};

    // stage 0: capture the request and set up the camera divide
    always_comb begin
        pipe_next[0]         = '0;
        pipe_next[0].cell_x  = s_player_x[FRAC_BITS +: CELL_W];
        pipe_next[0].cell_y  = s_player_y[FRAC_BITS +: CELL_W];
        pipe_next[0].frac_x  = s_player_x[FRAC_BITS-1:0];
        pipe_next[0].frac_y  = s_player_y[FRAC_BITS-1:0];
        pipe_next[0].dir_x   = s_view_dir_x;
        pipe_next[0].dir_y   = s_view_dir_y;
        pipe_next[0].pl_x    = s_plane_x;
        pipe_next[0].pl_y    = s_plane_y;
        // numerator is (2 * column) << FRAC_BITS
        pipe_next[0].cam_num = {s_column, 1'b0, FRAC_BITS'(0)};
    end

    for (genvar k = 1; k < NUM_STAGES; k++) begin : g_stage
        if (k < ST_CAM) begin : g_div1
            // camera divide, one quotient bit per stage
            always_comb pipe_next[k] = div1_step(pipe_reg[k-1], div_w);
        end else if (k == ST_CAM) begin : g_cam
            // cam = quotient - 1.0, then scale the plane by it
            logic signed [CAM_W-1:0] cam;
            always_comb begin
                cam          = $signed({1'b0, pipe_reg[k-1].cam_quo})
                               - (CAM_W'(1) << FRAC_BITS);
                pipe_next[k] = pipe_reg[k-1];
                pipe_next[k].prod_x = PROD_W'(pipe_reg[k-1].pl_x) * PROD_W'(cam);
                pipe_next[k].prod_y = PROD_W'(pipe_reg[k-1].pl_y) * PROD_W'(cam);
            end
        end else if (k == ST_RAY) begin : g_ray
            // floor shift, add the view direction, saturate, take magnitudes
            logic signed [RAY_W-1:0] rx;
            logic signed [RAY_W-1:0] ry;
            always_comb begin
                rx           = ray_sat(pipe_reg[k-1].dir_x, pipe_reg[k-1].prod_x);
                ry           = ray_sat(pipe_reg[k-1].dir_y, pipe_reg[k-1].prod_y);
                pipe_next[k] = pipe_reg[k-1];
                pipe_next[k].ray_x = rx;
                pipe_next[k].ray_y = ry;
                pipe_next[k].mag_x = rx[RAY_W-1] ? RAY_W'(-rx) : RAY_W'(rx);
                pipe_next[k].mag_y = ry[RAY_W-1] ? RAY_W'(-ry) : RAY_W'(ry);
            end
        end else if (k == ST_SQ) begin : g_sq
            // squared length of the ray
            always_comb begin
                pipe_next[k] = pipe_reg[k-1];
                pipe_next[k].sq_num  = SQ_W'(pipe_reg[k-1].mag_x) * SQ_W'(pipe_reg[k-1].mag_x)
                                     + SQ_W'(pipe_reg[k-1].mag_y) * SQ_W'(pipe_reg[k-1].mag_y);
                pipe_next[k].sq_rem  = '0;
                pipe_next[k].sq_root = '0;
            end
        end else if (k < ST_HYP) begin : g_sqrt
            always_comb pipe_next[k] = sqrt_step(pipe_reg[k-1]);
        end else if (k == ST_HYP) begin : g_hyp
            // load both delta divides with hyp << FRAC_BITS
            always_comb begin
                pipe_next[k] = pipe_reg[k-1];
                pipe_next[k].dvx_num = {pipe_reg[k-1].sq_root, FRAC_BITS'(0)};
                pipe_next[k].dvy_num = {pipe_reg[k-1].sq_root, FRAC_BITS'(0)};
                pipe_next[k].dvx_rem = '0;
                pipe_next[k].dvy_rem = '0;
                pipe_next[k].dvx_quo = '0;
                pipe_next[k].dvy_quo = '0;
            end
        end else if (k < ST_DELTA) begin : g_div2
            always_comb pipe_next[k] = div2_step(pipe_reg[k-1]);
        end else if (k == ST_DELTA) begin : g_delta
            // saturate deltas, pick the distance to the first side
            always_comb begin
                pipe_next[k] = pipe_reg[k-1];
                pipe_next[k].delta_x = delta_of(pipe_reg[k-1].mag_x, pipe_reg[k-1].dvx_quo);
                pipe_next[k].delta_y = delta_of(pipe_reg[k-1].mag_y, pipe_reg[k-1].dvy_quo);
                pipe_next[k].dist_x  = dist_of(pipe_reg[k-1].ray_x[RAY_W-1],
                                               pipe_reg[k-1].frac_x);
                pipe_next[k].dist_y  = dist_of(pipe_reg[k-1].ray_y[RAY_W-1],
                                               pipe_reg[k-1].frac_y);
            end
        end else if (k == ST_SIDE_MUL) begin : g_smul
            always_comb begin
                pipe_next[k] = pipe_reg[k-1];
                pipe_next[k].sprod_x = SIDE_PROD_W'(pipe_reg[k-1].dist_x)
                                     * SIDE_PROD_W'(pipe_reg[k-1].delta_x);
                pipe_next[k].sprod_y = SIDE_PROD_W'(pipe_reg[k-1].dist_y)
                                     * SIDE_PROD_W'(pipe_reg[k-1].delta_y);
            end
        end else begin : g_side
            // shift down and saturate the side distances
            always_comb begin
                pipe_next[k] = pipe_reg[k-1];
                pipe_next[k].side_x = side_of(pipe_reg[k-1].delta_x, pipe_reg[k-1].sprod_x);
                pipe_next[k].side_y = side_of(pipe_reg[k-1].delta_y, pipe_reg[k-1].sprod_y);
            end
        end
    end

    // valid bits travel with the data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (advance) begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            for (int i = 0; i < NUM_STAGES; i++) begin
                pipe_reg[i] <= pipe_next[i];
            end
        end
    end

    // the last stage is the output register
    assign m_valid      = vld_reg[NUM_STAGES-1];
    assign m_ray_x      = pipe_reg[NUM_STAGES-1].ray_x;
    assign m_ray_y      = pipe_reg[NUM_STAGES-1].ray_y;
    assign m_cell_x     = pipe_reg[NUM_STAGES-1].cell_x;
    assign m_cell_y     = pipe_reg[NUM_STAGES-1].cell_y;
    assign m_step_neg_x = pipe_reg[NUM_STAGES-1].ray_x[RAY_W-1];
    assign m_step_neg_y = pipe_reg[NUM_STAGES-1].ray_y[RAY_W-1];
    assign m_delta_x    = pipe_reg[NUM_STAGES-1].delta_x;
    assign m_delta_y    = pipe_reg[NUM_STAGES-1].delta_y;
    assign m_side_x     = pipe_reg[NUM_STAGES-1].side_x;
    assign m_side_y     = pipe_reg[NUM_STAGES-1].side_y;

`ifndef SYNTHESIS
    // a waiting result blocks new requests
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |-> !s_ready)
        else $error("request accepted while output stalled");

    // zero ray component saturates its delta
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ray_x == '0) |-> (m_delta_x == DIST_SAT))
        else $error("zero ray_x without saturated delta");

    // hypotenuse is never below a component, so delta is at least one
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ray_y != '0) |-> (m_delta_y >= (DIST_W'(1) << FRAC_BITS)))
        else $error("delta_y below one");

    // saturated delta forces saturated side distance
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_delta_x == DIST_SAT) |-> (m_side_x == DIST_SAT))
        else $error("side_x not saturated with delta_x");
`endif

endmodule

FILE: bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the ray setup pipeline: a directed table of rays is
// followed by constrained-by-hand random rays under several idle patterns and
// screen widths, every result checked in order against a predictor or table.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rrs_pkg::*;

    // one ray request as seen on the input channel
    typedef struct {
        logic [COL_W-1:0]        column;
        logic [POS_W-1:0]        px;
        logic [POS_W-1:0]        py;
        logic signed [VEC_W-1:0] dx;
        logic signed [VEC_W-1:0] dy;
        logic signed [VEC_W-1:0] plx;
        logic signed [VEC_W-1:0] ply;
    } ray_req_t;

    // one ray setup as seen on the result channel
    typedef struct {
        logic signed [RAY_W-1:0] rx;
        logic signed [RAY_W-1:0] ry;
        logic [CELL_W-1:0]       cx;
        logic [CELL_W-1:0]       cy;
        logic                    nx;
        logic                    ny;
        logic [DIST_W-1:0]       dlx;
        logic [DIST_W-1:0]       dly;
        logic [DIST_W-1:0]       sdx;
        logic [DIST_W-1:0]       sdy;
    } ray_setup_t;

    // directed row: width to run at, request, and an optional typed-in answer
    typedef struct {
        logic [WIDTH_W-1:0] width;
        ray_req_t           req;
        bit                 typed;
        ray_setup_t         res;
    } dir_row_t;

    localparam int ONE       = 1 << FRAC_BITS;
    localparam int DRAIN_CYC = 120;     // longer than the 93-stage pipeline
    localparam int WDOG_MAX  = 5000;    // cycles with no transfer at all
    localparam int N_DIR     = 14;

    logic                    aclk;
    logic                    aresetn;
    logic                    cfg_we;
    logic [WIDTH_W-1:0]      cfg_wdata;
    logic                    s_valid;
    logic                    s_ready;
    logic [COL_W-1:0]        s_column;
    logic [POS_W-1:0]        s_player_x;
    logic [POS_W-1:0]        s_player_y;
    logic signed [VEC_W-1:0] s_view_dir_x;
    logic signed [VEC_W-1:0] s_view_dir_y;
    logic signed [VEC_W-1:0] s_plane_x;
    logic signed [VEC_W-1:0] s_plane_y;
    logic                    m_valid;
    logic                    m_ready;
    logic signed [RAY_W-1:0] m_ray_x;
    logic signed [RAY_W-1:0] m_ray_y;
    logic [CELL_W-1:0]       m_cell_x;
    logic [CELL_W-1:0]       m_cell_y;
    logic                    m_step_neg_x;
    logic                    m_step_neg_y;
    logic [DIST_W-1:0]       m_delta_x;
    logic [DIST_W-1:0]       m_delta_y;
    logic [DIST_W-1:0]       m_side_x;
    logic [DIST_W-1:0]       m_side_y;

    // predictor copy of the width register
    logic [WIDTH_W-1:0] width_q;

    ray_setup_t pending_setups[$];
    int         mismatches;
    int         sender_idle;     // percent of cycles the sender sits out
    int         recv_stall;      // percent of cycles the receiver stalls
    int         hold_cycles;     // long receiver hold-off, counted down
    bit         done;
    int         quiet_cycles;
    dir_row_t   dir_tbl[N_DIR];

    raycast_ray_setup uut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_column     (s_column),
        .s_player_x   (s_player_x),
        .s_player_y   (s_player_y),
        .s_view_dir_x (s_view_dir_x),
        .s_view_dir_y (s_view_dir_y),
        .s_plane_x    (s_plane_x),
        .s_plane_y    (s_plane_y),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_ray_x      (m_ray_x),
        .m_ray_y      (m_ray_y),
        .m_cell_x     (m_cell_x),
        .m_cell_y     (m_cell_y),
        .m_step_neg_x (m_step_neg_x),
        .m_step_neg_y (m_step_neg_y),
        .m_delta_x    (m_delta_x),
        .m_delta_y    (m_delta_y),
        .m_side_x     (m_side_x),
        .m_side_y     (m_side_y)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // delta and first-side distance on one axis
    function automatic void axis_dist(input longint unsigned hyp, input longint comp,
                                      input logic [FRAC_BITS-1:0] frac,
                                      output logic [DIST_W-1:0] delta,
                                      output logic [DIST_W-1:0] side);
        longint unsigned mag, q, gap, s;
        if (comp == 0) begin
            delta = DIST_SAT;
            side  = DIST_SAT;
            return;
        end
        mag = (comp < 0) ? -comp : comp;
        q = (hyp << FRAC_BITS) / mag;
        delta = (q > 64'hFFFF_FFFF) ? DIST_SAT : q[DIST_W-1:0];
        if (delta == DIST_SAT) begin
            side = DIST_SAT;
            return;
        end
        // heading negative: distance back to the cell's low edge
        gap = (comp < 0) ? frac : ONE - frac;
        s = (gap * delta) >> FRAC_BITS;
        side = (s > 64'hFFFF_FFFF) ? DIST_SAT : s[DIST_W-1:0];
    endfunction

    function automatic ray_setup_t predict_setup(input ray_req_t q);
        ray_setup_t r;
        longint w, cam, rx, ry;
        longint unsigned n, root, b;
        w   = (width_q == 0) ? 1 : width_q;      // zero width acts as one
        cam = ((longint'(q.column) * 2) << FRAC_BITS) / w - ONE;
        rx  = longint'(q.dx) + ((longint'(q.plx) * cam) >>> FRAC_BITS);
        ry  = longint'(q.dy) + ((longint'(q.ply) * cam) >>> FRAC_BITS);
        if (rx > RAY_MAX) rx = RAY_MAX;
        if (rx < RAY_MIN) rx = RAY_MIN;
        if (ry > RAY_MAX) ry = RAY_MAX;
        if (ry < RAY_MIN) ry = RAY_MIN;
        // integer square root of the squared length
        n = rx * rx + ry * ry;
        root = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= root + b) begin
                n -= root + b;
                root = (root >> 1) + b;
            end else begin
                root >>= 1;
            end
            b >>= 2;
        end
        r.rx = rx[RAY_W-1:0];
        r.ry = ry[RAY_W-1:0];
        r.cx = q.px[FRAC_BITS +: CELL_W];        // cell wraps with the map
        r.cy = q.py[FRAC_BITS +: CELL_W];
        r.nx = rx < 0;
        r.ny = ry < 0;
        axis_dist(root, rx, q.px[FRAC_BITS-1:0], r.dlx, r.sdx);
        axis_dist(root, ry, q.py[FRAC_BITS-1:0], r.dly, r.sdy);
        return r;
    endfunction

    function automatic logic signed [VEC_W-1:0] rand_vec();
        // mostly the legal range, sometimes any bit pattern
        if ($urandom_range(7) == 0)
            return VEC_W'($urandom);
        return VEC_W'(int'($urandom_range(262144)) - 131072);
    endfunction

    function automatic ray_req_t rand_req();
        ray_req_t q;
        int wmax;
        wmax = (width_q == 0) ? 0 : width_q - 1;
        if (wmax > 4095) wmax = 4095;
        q.column = ($urandom_range(9) == 0) ? COL_W'($urandom) : COL_W'($urandom_range(wmax));
        q.px  = POS_W'($urandom);
        q.py  = POS_W'($urandom);
        q.dx  = rand_vec();
        q.dy  = rand_vec();
        q.plx = rand_vec();
        q.ply = rand_vec();
        // now and then force a zero ray component on one axis
        case ($urandom_range(11))
            0: begin q.dx = '0; q.plx = '0; end
            1: begin q.dy = '0; q.ply = '0; end
            default: ;
        endcase
        return q;
    endfunction

    // offer one request, hold it until taken, then log its expected setup
    task automatic send_req(input ray_req_t q, input bit typed, input ray_setup_t tres);
        @(negedge aclk);
        while ($urandom_range(99) < sender_idle) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_column     = q.column;
        s_player_x   = q.px;
        s_player_y   = q.py;
        s_view_dir_x = q.dx;
        s_view_dir_y = q.dy;
        s_plane_x    = q.plx;
        s_plane_y    = q.ply;
        s_valid      = 1'b1;
        do @(posedge aclk); while (!s_ready);
        pending_setups.push_back(typed ? tres : predict_setup(q));
    endtask

    // stop offering, wait out every result and the pipeline tail
    task automatic drain();
        @(negedge aclk);
        s_valid = 1'b0;
        while (pending_setups.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYC) @(posedge aclk);
    endtask

    task automatic write_width(input logic [WIDTH_W-1:0] v);
        @(negedge aclk);
        cfg_we    = 1'b1;
        cfg_wdata = v;
        @(negedge aclk);
        cfg_we    = 1'b0;
        width_q   = v;
    endtask

    // receiver: random stalls, plus a long hold-off when asked for
    initial begin
        m_ready = 1'b1;
        forever begin
            @(negedge aclk);
            if (hold_cycles > 0) begin
                m_ready = 1'b0;
                hold_cycles--;
            end else begin
                m_ready = ($urandom_range(99) >= recv_stall);
            end
        end
    end

    // result checker against the oldest pending setup
    always @(posedge aclk) begin
        ray_setup_t e;
        if (aresetn && m_valid && m_ready) begin
            if (pending_setups.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: ray_x=%0d ray_y=%0d", m_ray_x, m_ray_y);
            end else begin
                e = pending_setups.pop_front();
                if (m_ray_x !== e.rx || m_ray_y !== e.ry || m_cell_x !== e.cx ||
                    m_cell_y !== e.cy || m_step_neg_x !== e.nx || m_step_neg_y !== e.ny ||
                    m_delta_x !== e.dlx || m_delta_y !== e.dly ||
                    m_side_x !== e.sdx || m_side_y !== e.sdy) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch exp: ray %0d %0d cell %0d %0d neg %b%b",
                                 e.rx, e.ry, e.cx, e.cy, e.nx, e.ny);
                        $display("    delta %h %h side %h %h", e.dlx, e.dly, e.sdx, e.sdy);
                        $display("mismatch got: ray %0d %0d cell %0d %0d neg %b%b",
                                 m_ray_x, m_ray_y, m_cell_x, m_cell_y,
                                 m_step_neg_x, m_step_neg_y);
                        $display("    delta %h %h side %h %h",
                                 m_delta_x, m_delta_y, m_side_x, m_side_y);
                    end
                end
            end
        end
    end

    // watchdog on cycles with no transfer on either channel
    initial begin
        quiet_cycles = 0;
        forever begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WDOG_MAX && !done) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial begin
        ray_setup_t none;
        logic [WIDTH_W-1:0] widths[6];
        int phase;

        aresetn      = 1'b0;
        cfg_we       = 1'b0;
        cfg_wdata    = '0;
        s_valid      = 1'b0;
        s_column     = '0;
        s_player_x   = '0;
        s_player_y   = '0;
        s_view_dir_x = '0;
        s_view_dir_y = '0;
        s_plane_x    = '0;
        s_plane_y    = '0;
        sender_idle  = 0;
        recv_stall   = 0;
        hold_cycles  = 0;
        mismatches   = 0;
        done         = 1'b0;
        width_q      = WIDTH_RESET;
        none         = '{default: '0};

        // centre column at reset width: ray straight down +x
        dir_tbl[0] = '{13'd640, '{12'd320, 24'h0A8000, 24'h050000, 19'sd65536, 19'sd0,
                                 19'sd0, 19'sd43690},
                       1, '{20'sd65536, 20'sd0, 8'd10, 8'd5, 1'b0, 1'b0,
                            32'h0001_0000, DIST_SAT, 32'h0000_8000, DIST_SAT}};
        // left edge: cam is -1, ray -x, position on a cell boundary
        dir_tbl[1] = '{13'd640, '{12'd0, 24'h030000, 24'h040000, 19'sd0, 19'sd0,
                                 19'sd65536, 19'sd0},
                       1, '{-20'sd65536, 20'sd0, 8'd3, 8'd4, 1'b1, 1'b0,
                            32'h0001_0000, DIST_SAT, 32'h0, DIST_SAT}};
        // zero ray on both axes
        dir_tbl[2] = '{13'd640, '{12'd320, 24'hFFFFFF, 24'h000000, 19'sd0, 19'sd0,
                                 19'sd1000, -19'sd1000},
                       1, '{20'sd0, 20'sd0, 8'd255, 8'd0, 1'b0, 1'b0,
                            DIST_SAT, DIST_SAT, DIST_SAT, DIST_SAT}};
        // extremes, checked by the predictor
        dir_tbl[3] = '{13'd640, '{12'd4095, 24'hFFFFFF, 24'hFFFFFF, 19'sd131072,
                                 -19'sd131072, 19'sd131072, 19'sd131072}, 0, none};
        dir_tbl[4] = '{13'd640, '{12'd4095, 24'h0, 24'h0, -19'sd262144, 19'sd262143,
                                 -19'sd262144, 19'sd262143}, 0, none};
        dir_tbl[5] = '{13'd640, '{12'd639, 24'h123456, 24'hABCDEF, 19'sd1, -19'sd1,
                                 19'sd0, 19'sd0}, 0, none};
        dir_tbl[6] = '{13'd640, '{12'd100, 24'h7FFFFF, 24'h800000, 19'sd3, 19'sd262143,
                                 19'sd1, -19'sd1}, 0, none};
        // zero width behaves as a width of one
        dir_tbl[7] = '{13'd0, '{12'd4095, 24'h010000, 24'h020000, 19'sd65536, 19'sd0,
                                 19'sd1, 19'sd1}, 0, none};
        dir_tbl[8] = '{13'd0, '{12'd0, 24'hFFFF00, 24'h00FFFF, 19'sd0, 19'sd65536,
                                 19'sd65536, 19'sd0}, 0, none};
        dir_tbl[9] = '{13'd1, '{12'd1, 24'h0, 24'h0, 19'sd0, 19'sd0,
                                 19'sd131072, -19'sd131072}, 0, none};
        // widest setting and an over-range width
        dir_tbl[10] = '{13'd4096, '{12'd4095, 24'h5A5A5A, 24'hA5A5A5, -19'sd65536,
                                  19'sd65536, 19'sd43690, 19'sd43690}, 0, none};
        dir_tbl[11] = '{13'd4096, '{12'd2048, 24'hFFFFFF, 24'h0, 19'sd0, -19'sd65536,
                                  19'sd1, 19'sd1}, 0, none};
        dir_tbl[12] = '{13'd8191, '{12'd4095, 24'h010001, 24'hFEFFFF, 19'sd100,
                                  19'sd100, -19'sd262144, 19'sd262143}, 0, none};
        dir_tbl[13] = '{13'd8191, '{12'd0, 24'hFFFFFF, 24'hFFFFFF, 19'sd262143,
                                  -19'sd262144, 19'sd262143, -19'sd262144}, 0, none};

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed table, starting from the reset width
        foreach (dir_tbl[i]) begin
            if (dir_tbl[i].width != width_q) begin
                drain();
                write_width(dir_tbl[i].width);
            end
            send_req(dir_tbl[i].req, dir_tbl[i].typed, dir_tbl[i].res);
        end
        drain();

        // pipeline fill: receiver holds off while requests keep coming
        write_width(WIDTH_RESET);
        hold_cycles = 400;
        repeat (150) send_req(rand_req(), 0, none);
        drain();

        widths = '{13'd640, 13'd1, 13'd4096, 13'd0, 13'd8191, 13'd320};
        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin sender_idle = 0;  recv_stall = 0;  end
                1: begin sender_idle = 56; recv_stall = 0;  end
                2: begin sender_idle = 0;  recv_stall = 56; end
                default: begin sender_idle = 8; recv_stall = 8; end
            endcase
            foreach (widths[k]) begin
                write_width((k == 5) ? WIDTH_W'($urandom_range(1, 4096)) : widths[k]);
                repeat (55) send_req(rand_req(), 0, none);
                drain();
            end
        end

        done = 1'b1;
        if (mismatches == 0 && pending_setups.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
